### sv/ctme_pkg.sv
// ----------------------------------------------------------------------------
// ctme_pkg
// shared constants, codes and types of the cow tape machine execution unit
// ----------------------------------------------------------------------------
package ctme_pkg;

   localparam int TAPE_DEPTH  = 16384;
   localparam int HEAD_W      = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;
   localparam int CELL_W      = 32;
   localparam int OP_W        = 4;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   typedef enum logic [OP_W-1:0] {
      OP_LOOP_CLOSE = 4'd0,
      OP_HEAD_LEFT  = 4'd1,
      OP_HEAD_RIGHT = 4'd2,
      OP_INDIRECT   = 4'd3,
      OP_CHAR_IO    = 4'd4,
      OP_DEC        = 4'd5,
      OP_INC        = 4'd6,
      OP_LOOP_OPEN  = 4'd7,
      OP_ZERO       = 4'd8,
      OP_HOLD       = 4'd9,
      OP_INT_OUT    = 4'd10,
      OP_INT_IN     = 4'd11
   } op_type;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_CHAR = 2'd1,
      KIND_INT  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      FAULT_NONE      = 2'd0,
      FAULT_SELF_EXEC = 2'd1,
      FAULT_TAPE_END  = 2'd2
   } fault_type;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'd0,
      ST_RUN   = 2'd1,
      ST_FETCH = 2'd2
   } state_type;

   // outcome of one instruction against the cached cell
   typedef struct packed {
      logic [CELL_W-1:0] new_cell;
      logic              cell_we;
      logic [HEAD_W-1:0] head_next;
      logic              head_changed;
      logic [CELL_W-1:0] held_value_next;
      logic              held_full_next;
      kind_type          out_kind;
      logic [CELL_W-1:0] out_value;
      logic              took_input;
      fault_type         fault;
   } exec_type;

endpackage

### sv/ctme_ram.sv
// ----------------------------------------------------------------------------
// ctme_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module ctme_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/ctme_exec.sv
// ----------------------------------------------------------------------------
// ctme_exec
// instruction decode and execute against the cached current cell
// ----------------------------------------------------------------------------
module ctme_exec (
   input  logic [ctme_pkg::OP_W-1:0]   op,
   input  logic [ctme_pkg::CELL_W-1:0] in_value,
   input  logic                        in_present,
   input  logic [ctme_pkg::CELL_W-1:0] cur_cell,
   input  logic [ctme_pkg::HEAD_W-1:0] head,
   input  logic [ctme_pkg::CELL_W-1:0] held_value,
   input  logic                        held_full,
   output ctme_pkg::exec_type          res
);

   localparam logic [ctme_pkg::HEAD_W-1:0] HEAD_LAST =
      ctme_pkg::HEAD_W'(ctme_pkg::TAPE_DEPTH - 1);

   logic [ctme_pkg::OP_W-1:0] eff_op;
   ctme_pkg::fault_type       ind_fault;

   // indirection picks the opcode out of the cell
   always_comb begin
      eff_op    = op;
      ind_fault = ctme_pkg::FAULT_NONE;
      if (op == ctme_pkg::OP_INDIRECT) begin
         if (cur_cell == ctme_pkg::CELL_W'(ctme_pkg::OP_INDIRECT)) begin
            eff_op    = ctme_pkg::OP_LOOP_CLOSE;
            ind_fault = ctme_pkg::FAULT_SELF_EXEC;
         end else if (cur_cell > ctme_pkg::CELL_W'(ctme_pkg::OP_INT_IN)) begin
            eff_op = ctme_pkg::OP_LOOP_CLOSE;
         end else begin
            eff_op = cur_cell[ctme_pkg::OP_W-1:0];
         end
      end
   end

   always_comb begin
      res                 = '0;
      res.new_cell        = cur_cell;
      res.head_next       = head;
      res.held_value_next = held_value;
      res.held_full_next  = held_full;
      res.out_kind        = ctme_pkg::KIND_NONE;
      res.fault           = ind_fault;
      unique case (eff_op)
         ctme_pkg::OP_HEAD_LEFT: begin
            if (head != '0) begin
               res.head_next    = head - 1'b1;
               res.head_changed = 1'b1;
            end
         end
         ctme_pkg::OP_HEAD_RIGHT: begin
            if (head != HEAD_LAST) begin
               res.head_next    = head + 1'b1;
               res.head_changed = 1'b1;
            end else begin
               res.fault = ctme_pkg::FAULT_TAPE_END;
            end
         end
         ctme_pkg::OP_CHAR_IO: begin
            if (cur_cell == '0) begin
               res.took_input = 1'b1;
               res.cell_we    = 1'b1;
               res.new_cell   = in_present ? {24'd0, in_value[7:0]} : '0;
            end else begin
               res.out_kind  = ctme_pkg::KIND_CHAR;
               res.out_value = {24'd0, cur_cell[7:0]};
            end
         end
         ctme_pkg::OP_DEC: begin
            res.cell_we  = 1'b1;
            res.new_cell = cur_cell - 1'b1;
         end
         ctme_pkg::OP_INC: begin
            res.cell_we  = 1'b1;
            res.new_cell = cur_cell + 1'b1;
         end
         ctme_pkg::OP_ZERO: begin
            res.cell_we  = 1'b1;
            res.new_cell = '0;
         end
         ctme_pkg::OP_HOLD: begin
            if (!held_full) begin
               res.held_value_next = cur_cell;
               res.held_full_next  = 1'b1;
            end else begin
               res.cell_we        = 1'b1;
               res.new_cell       = held_value;
               res.held_full_next = 1'b0;
            end
         end
         ctme_pkg::OP_INT_OUT: begin
            res.out_kind  = ctme_pkg::KIND_INT;
            res.out_value = cur_cell;
         end
         ctme_pkg::OP_INT_IN: begin
            res.took_input = 1'b1;
            res.cell_we    = 1'b1;
            res.new_cell   = in_present ? in_value : '0;
         end
         default: begin
            // loop opcodes and unused codes leave everything alone
         end
      endcase
   end

endmodule

### sv/cow_tape_machine_execute.sv
// ----------------------------------------------------------------------------
// cow_tape_machine_execute
// execution unit of a cow tape machine: tape in a synchronous memory,
// current cell cached in a register, one result transfer per instruction
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata (low bit up)                         | tuser
//  --------+-----+--------------------------------------------+--------------
//  req_    | in  | op[3:0], in_value[35:4], zero pad [39:36]  | in_present
//  rsp_    | out | out_value[31:0], took_input[32],           | out_kind[1:0]
//          |     | cell_zero[33], fault[35:34], zero pad      |
//
//  moves: an instruction that keeps the head in place needs no fetch state;
//    a move that changes the head passes through the fetch state, for the
//    registered read of the new cell out of the tape memory
//  reset: a clearing pass writes zero to every tape cell, one a cycle, over
//    all TAPE_DEPTH (16384) cells, during which req_tready stays low
//  stalls: the result register is refilled in the cycle its transfer
//    leaves; req_tready drops only while rsp is full and stalled, while a
//    move fetches its new cell, or during the clearing pass
//
module cow_tape_machine_execute (
   input  logic                             clock,
   input  logic                             reset,
   // request side
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ctme_pkg::REQ_TDATA_W-1:0] req_tdata,  // op, in_value, pad
   input  logic                             req_tuser,  // in_present
   // result side
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ctme_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // out_value, took_input,
                                                        // cell_zero, fault, pad
   output logic [1:0]                       rsp_tuser   // out_kind
);

   localparam int HW = ctme_pkg::HEAD_W;
   localparam int CW = ctme_pkg::CELL_W;
   localparam logic [HW-1:0] HEAD_LAST = HW'(ctme_pkg::TAPE_DEPTH - 1);

   // control state
   ctme_pkg::state_type state_ff, state_in;
   logic [HW-1:0]       clr_addr_ff, clr_addr_in;
   logic [HW-1:0]       head_ff, head_in;
   logic [CW-1:0]       cur_cell_ff, cur_cell_in;   // mirrors tape[head] outside the fetch state
   logic [CW-1:0]       held_value_ff, held_value_in;
   logic                held_full_ff, held_full_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // result payload
   ctme_pkg::kind_type  out_kind_ff, out_kind_in;
   logic [CW-1:0]       out_value_ff, out_value_in;
   logic                took_ff, took_in;
   logic                zero_ff, zero_in;
   ctme_pkg::fault_type fault_ff, fault_in;

   // tape memory ports
   logic          wr_en;
   logic [HW-1:0] wr_addr;
   logic [CW-1:0] wr_data;
   logic          rd_en;
   logic [HW-1:0] rd_addr;
   logic [CW-1:0] rd_data;

   ctme_pkg::exec_type ex;
   logic               req_accept;

   // request fields
   logic [ctme_pkg::OP_W-1:0] req_op;
   logic [CW-1:0]             req_in_value;

   assign req_op       = req_tdata[3:0];
   assign req_in_value = req_tdata[35:4];

   assign req_tready = (state_ff == ctme_pkg::ST_RUN) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   ctme_exec u_exec (
      .op         (req_op),
      .in_value   (req_in_value),
      .in_present (req_tuser),
      .cur_cell   (cur_cell_ff),
      .head       (head_ff),
      .held_value (held_value_ff),
      .held_full  (held_full_ff),
      .res        (ex)
   );

   ctme_ram #(
      .WIDTH (CW),
      .DEPTH (ctme_pkg::TAPE_DEPTH)
   ) u_tape (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next state, memory access and result loading
   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      head_in       = head_ff;
      cur_cell_in   = cur_cell_ff;
      held_value_in = held_value_ff;
      held_full_in  = held_full_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      out_kind_in  = out_kind_ff;
      out_value_in = out_value_ff;
      took_in      = took_ff;
      zero_in      = zero_ff;
      fault_in     = fault_ff;

      wr_en   = 1'b0;
      wr_addr = head_ff;
      wr_data = ex.new_cell;
      rd_en   = 1'b0;
      rd_addr = ex.head_next;

      unique case (state_ff)
         ctme_pkg::ST_CLEAR: begin
            // zero sweep over the whole tape
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == HEAD_LAST) begin
               state_in = ctme_pkg::ST_RUN;
            end
         end
         ctme_pkg::ST_RUN: begin
            if (req_accept) begin
               wr_en         = ex.cell_we;
               held_value_in = ex.held_value_next;
               held_full_in  = ex.held_full_next;
               head_in       = ex.head_next;
               if (ex.head_changed) begin
                  // new cell arrives from the tape next cycle
                  rd_en    = 1'b1;
                  state_in = ctme_pkg::ST_FETCH;
               end else begin
                  cur_cell_in  = ex.new_cell;
                  rsp_valid_in = 1'b1;
                  out_kind_in  = ex.out_kind;
                  out_value_in = ex.out_value;
                  took_in      = ex.took_input;
                  zero_in      = (ex.new_cell == '0);
                  fault_in     = ex.fault;
               end
            end
         end
         ctme_pkg::ST_FETCH: begin
            // output register is empty here: it was free at the move's accept
            cur_cell_in  = rd_data;
            rsp_valid_in = 1'b1;
            out_kind_in  = ctme_pkg::KIND_NONE;
            out_value_in = '0;
            took_in      = 1'b0;
            zero_in      = (rd_data == '0);
            fault_in     = ctme_pkg::FAULT_NONE;
            state_in     = ctme_pkg::ST_RUN;
         end
         default: begin
            state_in = ctme_pkg::ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ctme_pkg::ST_CLEAR;
         clr_addr_ff   <= '0;
         head_ff       <= '0;
         cur_cell_ff   <= '0;
         held_value_ff <= '0;
         held_full_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         head_ff       <= head_in;
         cur_cell_ff   <= cur_cell_in;
         held_value_ff <= held_value_in;
         held_full_ff  <= held_full_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      out_kind_ff  <= out_kind_in;
      out_value_ff <= out_value_in;
      took_ff      <= took_in;
      zero_ff      <= zero_in;
      fault_ff     <= fault_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, fault_ff, zero_ff, took_ff, out_value_ff};
   assign rsp_tuser  = out_kind_ff;

   // a fetch only ever follows an accepted move
   a_fetch_after_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ctme_pkg::ST_FETCH) |-> $past(req_accept))
      else $error("fetch state entered without an accepted move");

   // the result slot is free while a move fetches its cell
   a_fetch_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ctme_pkg::ST_FETCH) |-> !rsp_valid_ff)
      else $error("result register occupied during fetch");

   // head stays on the tape
   a_head_in_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= HEAD_LAST)
      else $error("head beyond tape end");

   // no instruction is taken outside the run state or while the result is stalled
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (state_ff == ctme_pkg::ST_RUN) && !(rsp_valid_ff && !rsp_tready))
      else $error("instruction accepted while busy");

endmodule
